// ===== rtl/dcf_pkg.sv =====
// Shared types and constants for the directed cycle finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcf_pkg;

	// default sizes of the graph stores
	localparam int MaxNodesDef = 1024;
	localparam int MaxEdgesDef = 2048;

	// fixed widths of the request and response fields
	localparam int FieldW = 11;
	localparam int CfgAddrW = 3;

	// register index, taken from paddr[2]
	localparam logic RegNodeCount = 1'b0;

	typedef enum logic [1:0] {
		CMD_ADD    = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_READ   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		RES_OK    = 2'd0,
		RES_FULL  = 2'd1,
		RES_RANGE = 2'd2
	} res_t;

	// visit marks
	localparam logic [1:0] VmNew  = 2'd0;
	localparam logic [1:0] VmPath = 2'd1;
	localparam logic [1:0] VmDone = 2'd2;

	typedef enum logic [3:0] {
		ST_INIT,
		ST_IDLE,
		ST_ADD,
		ST_LINK,
		ST_CLEAR,
		ST_READ,
		ST_VCLR,
		ST_ROOT,
		ST_ROOT_CHK,
		ST_LOAD,
		ST_STEP,
		ST_POPLD,
		ST_EDGE,
		ST_VCHK,
		ST_RESP
	} state_t;

	// datapath operations issued by the controller
	typedef enum logic [4:0] {
		OP_NONE,
		OP_SWEEP_FE,
		OP_ACCEPT,
		OP_ADD_WRITE,
		OP_ADD_LINK,
		OP_ADD_FAIL,
		OP_READ_FINISH,
		OP_SWEEP_VM,
		OP_ROOT_READ,
		OP_ROOT_NEXT,
		OP_ROOT_START,
		OP_LOAD_CUR,
		OP_POP,
		OP_POP_LOAD,
		OP_EDGE_READ,
		OP_EDGE_TAKE,
		OP_PUSH,
		OP_FOUND,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t op;
	} ctl_cmd_t;

	typedef struct packed {
		logic sweep_fe_last;
		logic sweep_vm_last;
		logic n_zero;
		logic add_bad;
		logic add_full;
		logic link_needed;
		logic root_seen;
		logic root_last;
		logic cur_empty;
		logic depth_one;
		logic edge_skip;
		logic v_on_path;
		logic v_can_push;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/dcf_ctrl.sv =====
// Controller state machine of the directed cycle finder.
// Depends on dcf_pkg; drives datapath operations from its status.
`timescale 1ns / 1ps

module dcf_ctrl import dcf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	input  logic [1:0] command,
	output logic     req_stall,
	input  dp_stat_t stat,
	output ctl_cmd_t cmd
);

	state_t state_q, state_nx;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_INIT: begin
				if (stat.sweep_fe_last) state_nx = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_valid && !req_stall) begin
					case (cmd_t'(command))
						CMD_ADD:    state_nx = ST_ADD;
						CMD_CLEAR:  state_nx = ST_CLEAR;
						CMD_SEARCH: state_nx = ST_VCLR;
						default:    state_nx = ST_READ;
					endcase
				end
			end
			ST_ADD: begin
				if (stat.add_bad || stat.add_full) state_nx = ST_RESP;
				else if (stat.link_needed) state_nx = ST_LINK;
				else state_nx = ST_RESP;
			end
			ST_LINK:  state_nx = ST_RESP;
			ST_CLEAR: begin
				if (stat.sweep_fe_last) state_nx = ST_RESP;
			end
			ST_READ:  state_nx = ST_RESP;
			ST_VCLR: begin
				if (stat.n_zero) state_nx = ST_RESP;
				else if (stat.sweep_vm_last) state_nx = ST_ROOT;
			end
			ST_ROOT:  state_nx = ST_ROOT_CHK;
			ST_ROOT_CHK: begin
				if (!stat.root_seen) state_nx = ST_LOAD;
				else if (stat.root_last) state_nx = ST_RESP;
				else state_nx = ST_ROOT;
			end
			ST_LOAD:  state_nx = ST_STEP;
			ST_STEP: begin
				if (!stat.cur_empty) state_nx = ST_EDGE;
				else if (!stat.depth_one) state_nx = ST_POPLD;
				else if (stat.root_last) state_nx = ST_RESP;
				else state_nx = ST_ROOT;
			end
			ST_POPLD: state_nx = ST_STEP;
			ST_EDGE: begin
				state_nx = stat.edge_skip ? ST_STEP : ST_VCHK;
			end
			ST_VCHK: begin
				if (stat.v_on_path) state_nx = ST_RESP;
				else if (stat.v_can_push) state_nx = ST_LOAD;
				else state_nx = ST_STEP;
			end
			ST_RESP: begin
				if (stat.out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_INIT;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op = OP_NONE;
		req_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_INIT:  cmd.op = OP_SWEEP_FE;
			ST_IDLE: begin
				if (req_valid && !req_stall) cmd.op = OP_ACCEPT;
			end
			ST_ADD: begin
				if (stat.add_bad || stat.add_full) cmd.op = OP_ADD_FAIL;
				else cmd.op = OP_ADD_WRITE;
			end
			ST_LINK:  cmd.op = OP_ADD_LINK;
			ST_CLEAR: cmd.op = OP_SWEEP_FE;
			ST_READ:  cmd.op = OP_READ_FINISH;
			ST_VCLR: begin
				if (!stat.n_zero) cmd.op = OP_SWEEP_VM;
			end
			ST_ROOT:  cmd.op = OP_ROOT_READ;
			ST_ROOT_CHK: begin
				if (!stat.root_seen) cmd.op = OP_ROOT_START;
				else if (!stat.root_last) cmd.op = OP_ROOT_NEXT;
			end
			ST_LOAD:  cmd.op = OP_LOAD_CUR;
			ST_STEP:  cmd.op = stat.cur_empty ? OP_POP : OP_EDGE_READ;
			ST_POPLD: cmd.op = OP_POP_LOAD;
			ST_EDGE:  cmd.op = OP_EDGE_TAKE;
			ST_VCHK: begin
				if (stat.v_on_path) cmd.op = OP_FOUND;
				else if (stat.v_can_push) cmd.op = OP_PUSH;
			end
			ST_RESP: begin
				if (stat.out_free) cmd.op = OP_EMIT;
			end
			default: cmd.op = OP_NONE;
		endcase
	end

endmodule

// ===== rtl/dcf_dpath.sv =====
// Datapath of the directed cycle finder: edge lists, DFS stack, visit marks.
// Depends on dcf_pkg; operations come from dcf_ctrl.
`timescale 1ns / 1ps

module dcf_dpath import dcf_pkg::*; #(
	parameter int MAX_NODES = MaxNodesDef,
	parameter int MAX_EDGES = MaxEdgesDef
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ctl_cmd_t          cmd,
	output dp_stat_t          stat,
	input  logic [FieldW-1:0] node_count,
	input  logic [1:0]        command,
	input  logic [FieldW-1:0] source_node,
	input  logic [FieldW-1:0] dest_node,
	input  logic [FieldW-1:0] read_index,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output logic [1:0]        status,
	output logic              cycle_found,
	output logic [FieldW-1:0] cycle_length,
	output logic [FieldW-1:0] node_out
);

	localparam int NW = $clog2(MAX_NODES);
	localparam int EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int CW = $clog2(MAX_EDGES + 1);
	localparam int DW = $clog2(MAX_NODES + 1);
	localparam int LW = $clog2(MAX_NODES + 2);

	// memories
	logic [NW-1:0] et_mem [MAX_EDGES];
	logic [CW-1:0] en_mem [MAX_EDGES];
	logic [CW-1:0] fe_mem [MAX_NODES];
	logic [CW-1:0] le_mem [MAX_NODES];
	logic [1:0]    vm_mem [MAX_NODES];
	logic [NW-1:0] pos_mem [MAX_NODES];
	logic [NW-1:0] sn_mem [MAX_NODES];
	logic [CW-1:0] sc_mem [MAX_NODES];

	logic et_we, en_we, fe_we, le_we, vm_we, pos_we, sn_we, sc_we;
	logic et_re, en_re, fe_re, le_re, vm_re, pos_re, sn_re, sc_re;
	logic [EW-1:0] et_wa, en_wa, e_ra;
	logic [NW-1:0] fe_wa, le_wa, vm_wa, pos_wa, sn_wa, sc_wa;
	logic [NW-1:0] fe_ra, le_ra, vm_ra, sn_ra;
	logic [NW-1:0] et_wd, pos_wd, sn_wd;
	logic [CW-1:0] en_wd, fe_wd, le_wd, sc_wd;
	logic [1:0]    vm_wd;

	logic [NW-1:0] et_rd_q, pos_rd_q, sn_rd_q;
	logic [CW-1:0] en_rd_q, fe_rd_q, le_rd_q, sc_rd_q;
	logic [1:0]    vm_rd_q;

	// control registers
	logic [NW-1:0] sweep_q, root_q;
	logic [DW-1:0] depth_q;
	logic [CW-1:0] ec_q;
	logic [LW-1:0] found_len_q;
	logic          out_valid_q;

	// payload registers
	logic [FieldW-1:0] src_q, dst_q, idx_q;
	logic [NW-1:0]     top_node_q, v_q, cyc_base_q, cyc_close_q;
	logic [CW-1:0]     top_cur_q;
	logic [1:0]        res_status_q;
	logic [FieldW-1:0] res_node_q;
	logic [1:0]        out_status_q;
	logic [FieldW-1:0] out_len_q, out_node_q;
	logic              out_found_q;

	logic [DW-1:0] nlive;
	logic [NW-1:0] u_in, u_q;
	logic [CW-1:0] ec_inc;
	logic          read_bad, read_close;

	// live node count, clamped to the store size
	assign nlive = (32'(node_count) > MAX_NODES) ? DW'(MAX_NODES) : DW'(node_count);
	assign u_in = NW'(32'(source_node) - 32'd1);
	assign u_q = NW'(32'(src_q) - 32'd1);
	assign ec_inc = ec_q + CW'(1);
	assign read_bad = 32'(idx_q) >= 32'(found_len_q);
	assign read_close = 32'(idx_q) + 32'd1 == 32'(found_len_q);

	// status to the controller
	always_comb begin
		stat.sweep_fe_last = sweep_q == NW'(MAX_NODES - 1);
		stat.sweep_vm_last = 32'(sweep_q) + 32'd1 == 32'(nlive);
		stat.n_zero = nlive == '0;
		stat.add_bad = (src_q == '0) || (32'(src_q) > 32'(nlive)) ||
			(dst_q == '0) || (32'(dst_q) > 32'(nlive));
		stat.add_full = 32'(ec_q) >= MAX_EDGES;
		stat.link_needed = fe_rd_q != '0;
		stat.root_seen = vm_rd_q != VmNew;
		stat.root_last = 32'(root_q) + 32'd1 >= 32'(nlive);
		stat.cur_empty = top_cur_q == '0;
		stat.depth_one = depth_q == DW'(1);
		stat.edge_skip = 32'(et_rd_q) >= 32'(nlive);
		stat.v_on_path = vm_rd_q == VmPath;
		stat.v_can_push = (vm_rd_q == VmNew) && (32'(depth_q) < MAX_NODES);
		stat.out_free = !out_valid_q || !rsp_stall;
	end

	// memory port control per operation
	always_comb begin
		{et_we, en_we, fe_we, le_we, vm_we, pos_we, sn_we, sc_we} = '0;
		{et_re, en_re, fe_re, le_re, vm_re, pos_re, sn_re, sc_re} = '0;
		et_wa = '0; en_wa = '0; e_ra = '0;
		fe_wa = '0; le_wa = '0; vm_wa = '0; pos_wa = '0; sn_wa = '0; sc_wa = '0;
		fe_ra = '0; le_ra = '0; vm_ra = '0; sn_ra = '0;
		et_wd = '0; pos_wd = '0; sn_wd = '0;
		en_wd = '0; fe_wd = '0; le_wd = '0; sc_wd = '0;
		vm_wd = VmNew;
		case (cmd.op)
			OP_SWEEP_FE: begin
				fe_we = 1'b1;
				fe_wa = sweep_q;
			end
			OP_ACCEPT: begin
				fe_re = 1'b1;
				le_re = 1'b1;
				fe_ra = u_in;
				le_ra = u_in;
				sn_re = 1'b1;
				sn_ra = NW'(32'(cyc_base_q) + 32'(read_index));
			end
			OP_ADD_WRITE: begin
				et_we = 1'b1;
				et_wa = EW'(ec_q);
				et_wd = NW'(32'(dst_q) - 32'd1);
				en_we = 1'b1;
				en_wa = EW'(ec_q);
				fe_we = fe_rd_q == '0;
				fe_wa = u_q;
				fe_wd = ec_inc;
				le_we = 1'b1;
				le_wa = u_q;
				le_wd = ec_inc;
			end
			OP_ADD_LINK: begin
				en_we = 1'b1;
				en_wa = EW'(le_rd_q - CW'(1));
				en_wd = ec_q;
			end
			OP_SWEEP_VM: begin
				vm_we = 1'b1;
				vm_wa = sweep_q;
			end
			OP_ROOT_READ: begin
				vm_re = 1'b1;
				vm_ra = root_q;
			end
			OP_ROOT_START: begin
				vm_we = 1'b1;
				vm_wa = root_q;
				vm_wd = VmPath;
				sn_we = 1'b1;
				sn_wd = root_q;
				pos_we = 1'b1;
				pos_wa = root_q;
				fe_re = 1'b1;
				fe_ra = root_q;
			end
			OP_POP: begin
				vm_we = 1'b1;
				vm_wa = top_node_q;
				vm_wd = VmDone;
				sn_re = !stat.depth_one;
				sc_re = !stat.depth_one;
				sn_ra = NW'(depth_q - DW'(2));
			end
			OP_EDGE_READ: begin
				et_re = 1'b1;
				en_re = 1'b1;
				e_ra = EW'(top_cur_q - CW'(1));
			end
			OP_EDGE_TAKE: begin
				vm_re = 1'b1;
				pos_re = 1'b1;
				vm_ra = et_rd_q;
			end
			OP_PUSH: begin
				vm_we = 1'b1;
				vm_wa = v_q;
				vm_wd = VmPath;
				sc_we = 1'b1;
				sc_wa = NW'(depth_q - DW'(1));
				sc_wd = top_cur_q;
				sn_we = 1'b1;
				sn_wa = NW'(depth_q);
				sn_wd = v_q;
				pos_we = 1'b1;
				pos_wa = v_q;
				pos_wd = NW'(depth_q);
				fe_re = 1'b1;
				fe_ra = v_q;
			end
			default: ;
		endcase
	end

	// edge store
	always_ff @(posedge clk) begin
		if (et_we) et_mem[et_wa] <= et_wd;
		if (et_re) et_rd_q <= et_mem[e_ra];
	end

	always_ff @(posedge clk) begin
		if (en_we) en_mem[en_wa] <= en_wd;
		if (en_re) en_rd_q <= en_mem[e_ra];
	end

	// per-node list heads and tails
	always_ff @(posedge clk) begin
		if (fe_we) fe_mem[fe_wa] <= fe_wd;
		if (fe_re) fe_rd_q <= fe_mem[fe_ra];
	end

	always_ff @(posedge clk) begin
		if (le_we) le_mem[le_wa] <= le_wd;
		if (le_re) le_rd_q <= le_mem[le_ra];
	end

	// visit marks and path positions
	always_ff @(posedge clk) begin
		if (vm_we) vm_mem[vm_wa] <= vm_wd;
		if (vm_re) vm_rd_q <= vm_mem[vm_ra];
	end

	always_ff @(posedge clk) begin
		if (pos_we) pos_mem[pos_wa] <= pos_wd;
		if (pos_re) pos_rd_q <= pos_mem[vm_ra];
	end

	// path stack; also holds the recorded cycle
	always_ff @(posedge clk) begin
		if (sn_we) sn_mem[sn_wa] <= sn_wd;
		if (sn_re) sn_rd_q <= sn_mem[sn_ra];
	end

	always_ff @(posedge clk) begin
		if (sc_we) sc_mem[sc_wa] <= sc_wd;
		if (sc_re) sc_rd_q <= sc_mem[sn_ra];
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			root_q <= '0;
			depth_q <= '0;
			ec_q <= '0;
			found_len_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// response register: loaded on emit, freed when taken
			if (cmd.op == OP_EMIT) out_valid_q <= 1'b1;
			else if (out_valid_q && !rsp_stall) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_SWEEP_FE: begin
					sweep_q <= stat.sweep_fe_last ? '0 : sweep_q + NW'(1);
					ec_q <= '0;
					found_len_q <= '0;
				end
				OP_ACCEPT: begin
					sweep_q <= '0;
					root_q <= '0;
					if (cmd_t'(command) == CMD_SEARCH) found_len_q <= '0;
				end
				OP_ADD_WRITE:  ec_q <= ec_inc;
				OP_SWEEP_VM:   sweep_q <= sweep_q + NW'(1);
				OP_ROOT_NEXT:  root_q <= root_q + NW'(1);
				OP_ROOT_START: depth_q <= DW'(1);
				OP_POP: begin
					depth_q <= depth_q - DW'(1);
					if (stat.depth_one) root_q <= root_q + NW'(1);
				end
				OP_PUSH:  depth_q <= depth_q + DW'(1);
				OP_FOUND: found_len_q <= LW'(depth_q) - LW'(pos_rd_q) + LW'(1);
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_ACCEPT: begin
				src_q <= source_node;
				dst_q <= dest_node;
				idx_q <= read_index;
				res_status_q <= RES_OK;
				res_node_q <= '0;
			end
			OP_ADD_FAIL: res_status_q <= stat.add_bad ? RES_RANGE : RES_FULL;
			OP_READ_FINISH: begin
				if (read_bad) res_status_q <= RES_RANGE;
				else if (read_close) res_node_q <= FieldW'(32'(cyc_close_q) + 32'd1);
				else res_node_q <= FieldW'(32'(sn_rd_q) + 32'd1);
			end
			OP_ROOT_START: top_node_q <= root_q;
			OP_LOAD_CUR:   top_cur_q <= fe_rd_q;
			OP_POP_LOAD: begin
				top_node_q <= sn_rd_q;
				top_cur_q <= sc_rd_q;
			end
			OP_EDGE_TAKE: begin
				top_cur_q <= en_rd_q;
				v_q <= et_rd_q;
			end
			OP_PUSH: top_node_q <= v_q;
			OP_FOUND: begin
				cyc_base_q <= pos_rd_q;
				cyc_close_q <= v_q;
			end
			OP_EMIT: begin
				out_status_q <= res_status_q;
				out_found_q <= found_len_q != '0;
				out_len_q <= FieldW'(found_len_q);
				out_node_q <= res_node_q;
			end
			default: ;
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign status = out_status_q;
	assign cycle_found = out_found_q;
	assign cycle_length = out_len_q;
	assign node_out = out_node_q;

endmodule

// ===== rtl/directed_cycle_finder.sv =====
// Directed cycle finder: serves add edge, read, clear and search requests.
// A search first sweeps the visit marks, then tries each root in turn, following
// edges and stepping back from nodes with no edges left.
// One request is worked at a time; the next is taken while a response waits.
// After reset the list heads are swept with req_stall high.
`timescale 1ns / 1ps

module directed_cycle_finder import dcf_pkg::*; #(
	parameter int MAX_NODES = MaxNodesDef,
	parameter int MAX_EDGES = MaxEdgesDef
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [CfgAddrW-1:0] paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          command,
	input  logic [FieldW-1:0]   source_node,
	input  logic [FieldW-1:0]   dest_node,
	input  logic [FieldW-1:0]   read_index,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [1:0]          status,
	output logic                cycle_found,
	output logic [FieldW-1:0]   cycle_length,
	output logic [FieldW-1:0]   node_out
);

	logic [FieldW-1:0] node_count_q;
	ctl_cmd_t          cmd;
	dp_stat_t          stat;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= FieldW'(1);
		end else if (psel && penable && pwrite && paddr[2] == RegNodeCount) begin
			node_count_q <= pwdata[FieldW-1:0];
		end
	end
	assign prdata = (paddr[2] == RegNodeCount) ? 32'(node_count_q) : '0;

	dcf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.command   (command),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dcf_dpath #(
		.MAX_NODES (MAX_NODES),
		.MAX_EDGES (MAX_EDGES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.node_count   (node_count_q),
		.command      (command),
		.source_node  (source_node),
		.dest_node    (dest_node),
		.read_index   (read_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.cycle_found  (cycle_found),
		.cycle_length (cycle_length),
		.node_out     (node_out)
	);

	// a taken request keeps the block busy the next cycle
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while block still busy");

	// a returned node only comes with a good status
	a_node_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && node_out != '0 |-> status == RES_OK)
		else $error("node returned with error status");

	// a nonzero length means a cycle was found
	a_len_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && cycle_length != '0 |-> cycle_found)
		else $error("cycle length without cycle flag");

endmodule
